@@ rtl/unsigned_to_ascii_digits_unit_assert.svh @@
// assertion macros for the rtl, used by unsigned_to_ascii_digits_unit.sv
`ifndef UNSIGNED_TO_ASCII_DIGITS_UNIT_ASSERT_SVH
`define UNSIGNED_TO_ASCII_DIGITS_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define U2A_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define U2A_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/u2a_pkg.sv @@
package u2a_pkg;

	localparam logic [7:0] DIGIT_ZERO     = 8'h30;
	localparam logic [7:0] HEX_LETTER_GAP = 8'd7;
	localparam logic [3:0] DEC_RADIX      = 4'd10;
	localparam logic [3:0] BCD_ADJ_LIMIT  = 4'd5;
	localparam logic [3:0] BCD_ADJ        = 4'd3;

	// control from the sequencer to the digit core
	typedef struct packed {
		logic load;   // take a new value
		logic hex;    // load the value as hex nibbles
		logic conv;   // one double-dabble step
		logic shift;  // drop the top digit
	} u2a_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} u2a_state_t;

	function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
		logic [7:0] c;
		c = DIGIT_ZERO + {4'd0, d};
		if (d >= DEC_RADIX) begin
			c = c + HEX_LETTER_GAP;
		end
		return c;
	endfunction

endpackage

@@ rtl/u2a_digit_core.sv @@
module u2a_digit_core
	import u2a_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int DIGIT_COUNT = 10
) (
	input  logic                   clk,
	input  u2a_ctrl_t              ctrl,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic [3:0]             top_digit
);

	localparam int DIG_BITS = DIGIT_COUNT * 4;

	logic [VALUE_WIDTH-1:0]        value_q;
	logic [DIGIT_COUNT-1:0][3:0]   digits_q;
	logic [DIGIT_COUNT-1:0][3:0]   digit_adj;
	logic [DIG_BITS-1:0]           adj_flat;
	logic [DIG_BITS-1:0]           digits_flat;

	// add-3 correction on every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			digit_adj[i] = (digits_q[i] >= BCD_ADJ_LIMIT) ? digits_q[i] + BCD_ADJ : digits_q[i];
		end
	end

	assign adj_flat    = digit_adj;
	assign digits_flat = digits_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= value;
			if (ctrl.hex) begin
				digits_q <= DIG_BITS'(value);
			end else begin
				digits_q <= '0;
			end
		end else if (ctrl.conv) begin
			digits_q <= {adj_flat[DIG_BITS-2:0], value_q[VALUE_WIDTH-1]};
			value_q  <= {value_q[VALUE_WIDTH-2:0], 1'b0};
		end else if (ctrl.shift) begin
			digits_q <= {digits_flat[DIG_BITS-5:0], 4'h0};
		end
	end

	assign top_digit = digits_q[DIGIT_COUNT-1];

endmodule

@@ rtl/unsigned_to_ascii_digits_unit.sv @@
// Converts one unsigned value to ASCII digits, decimal or uppercase hex (mode 1), most
// significant first, one item per character, leading zeros suppressed, zero giving a single
// '0', and last_digit set on the final character. Only one value is in flight: in_ready is
// high only while the unit is idle. A decimal value first goes through a serial loop of
// bit-serial double dabble (one input bit shifted into the bcd register per cycle) over all
// VALUE_WIDTH bits; then the DIGIT_COUNT digit slots (10 for 32 bits) are shifted out top
// first, one slot per cycle, except that a slot giving a character waits while out_ready is
// low. A hex value skips the conversion and goes straight to the digit slots. The unit then
// returns to idle, in which the next value is taken.
`include "unsigned_to_ascii_digits_unit_assert.svh"

module unsigned_to_ascii_digits_unit
	import u2a_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   mode,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             digit_char,
	output logic                   last_digit
);

	// decimal digits needed for VALUE_WIDTH bits, always enough for the hex nibbles too
	localparam int DIGIT_COUNT = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int REM_W       = $clog2(DIGIT_COUNT);

	u2a_state_t         state_q;
	logic [CNT_W-1:0]   bit_cnt_q;   // conversion steps done
	logic [REM_W-1:0]   rem_q;       // digit slots left after the top one
	logic               seen_q;      // a non-zero digit has gone out
	u2a_ctrl_t          ctrl;
	logic [3:0]         top_digit;
	logic               is_last;
	logic               lead_zero;
	logic               in_acc;
	logic               out_acc;

	u2a_digit_core #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_core (
		.clk       (clk),
		.ctrl      (ctrl),
		.value     (value),
		.top_digit (top_digit)
	);

	assign is_last   = (rem_q == '0);
	// leading zero slots are dropped without an item, but never the last slot
	assign lead_zero = !seen_q && (top_digit == 4'd0) && !is_last;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_EMIT) && !lead_zero;
	assign digit_char = digit_to_ascii(top_digit);
	assign last_digit = is_last;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_comb begin
		ctrl       = '0;
		ctrl.load  = in_acc;
		ctrl.hex   = mode;
		ctrl.conv  = (state_q == ST_CONV);
		ctrl.shift = (state_q == ST_EMIT) && (lead_zero || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			seen_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					bit_cnt_q <= '0;
					rem_q     <= REM_W'(DIGIT_COUNT - 1);
					seen_q    <= 1'b0;
					if (in_acc) begin
						// hex digits are the value's nibbles, no conversion needed
						state_q <= mode ? ST_EMIT : ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (lead_zero) begin
						rem_q <= rem_q - 1'b1;
					end else if (out_ready) begin
						seen_q <= 1'b1;
						rem_q  <= rem_q - 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// no new value while characters are still going out
	`U2A_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready,
		"output item while input side is open")
	// the final character closes the run
	`U2A_ASSERT_NXT(a_last_frees, clk, arst_n, out_acc && last_digit, in_ready,
		"unit not idle after last digit")
	// decimal values spend time converting before any character
	`U2A_ASSERT_NXT(a_dec_waits, clk, arst_n, in_acc && !mode, !out_valid,
		"character before decimal conversion")
	// every character is a digit or an uppercase hex letter
	`U2A_ASSERT_IMP(a_char_ok, clk, arst_n, out_valid,
		(digit_char >= 8'h30 && digit_char <= 8'h39) ||
		(digit_char >= 8'h41 && digit_char <= 8'h46),
		"character outside digit set")

endmodule
